@@ hw/rtl/p2pc_pkg.sv @@
// Shared types and constants for the power-of-two pair counter.
package p2pc_pkg;

  // Width of the running pair total and its modulus.
  localparam int unsigned TotalBits = 30;
  localparam logic [TotalBits-1:0] PairModulus = 30'd1000000007;

  // Width of the set tag stored with each histogram entry.
  localparam int unsigned EpochBits = 4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;   // write one zero entry of the clearing sweep
    logic load;    // take an input beat and start a new item
    logic scan;    // issue one histogram read
    logic reduce;  // one modular reduction step (first step also writes back)
    logic finish;  // load the result register and update the total
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;   // clearing sweep is at its last entry
    logic scan_done;  // the read of the item's own entry is being issued
    logic red_done;   // last reduction step this cycle
    logic out_free;   // result register can take a new result
    logic wrap_next;  // closing this set exhausts the set tags
  } sts_t;

endpackage

@@ hw/rtl/p2pc_ctrl.sv @@
// Controller state machine for the power-of-two pair counter.
module p2pc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  p2pc_pkg::sts_t sts_i,
  output p2pc_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    StClear  = 5'b00001,
    StIdle   = 5'b00010,
    StScan   = 5'b00100,
    StReduce = 5'b01000,
    StDone   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StClear: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_done) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = StReduce;
        end
      end
      StReduce: begin
        cmd_o.reduce = 1'b1;
        if (sts_i.red_done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = sts_i.wrap_next ? StClear : StIdle;
        end
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  // Input beats are taken only between items.
  assign in_stall_o = (state_q != StIdle);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/p2pc_dpath.sv @@
// Datapath of the power-of-two pair counter: histogram memory, accumulator and reduction.
module p2pc_dpath #(
  parameter int unsigned VALUE_BITS = 12,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  p2pc_pkg::cmd_t                   cmd_i,
  output p2pc_pkg::sts_t                   sts_o,
  input  logic [VALUE_BITS-1:0]            value_i,
  input  logic                             last_item_i,
  input  logic                             out_stall_i,
  output logic                             out_valid_o,
  output logic [p2pc_pkg::TotalBits-1:0]   pair_total_o,
  output logic                             is_final_o
);

  localparam int unsigned Depth   = 1 << VALUE_BITS;
  localparam int unsigned EpW     = p2pc_pkg::EpochBits;
  localparam int unsigned TotW    = p2pc_pkg::TotalBits;
  localparam int unsigned MemW    = EpW + COUNT_BITS;
  localparam int unsigned KW      = $clog2(VALUE_BITS + 2);
  // Accumulator holds the old total plus up to VALUE_BITS+1 raw counts.
  localparam int unsigned SumW    = (COUNT_BITS + KW > TotW) ? COUNT_BITS + KW : TotW;
  localparam int unsigned AccW    = SumW + 1;
  localparam int unsigned RedSteps = AccW - TotW + 1;
  localparam int unsigned RedW    = $clog2(RedSteps);
  localparam int unsigned PowW    = VALUE_BITS + 1;
  localparam logic [KW-1:0]   KOwn   = KW'(VALUE_BITS + 1);
  localparam logic [RedW-1:0] RedLast = RedW'(RedSteps - 1);
  localparam logic [AccW-1:0] ModTop =
      AccW'(p2pc_pkg::PairModulus) << (RedSteps - 1);

  // Histogram memory: set tag and count per value.
  logic [MemW-1:0]       mem_q [Depth];
  logic [MemW-1:0]       rd_q;
  logic                  mem_we;
  logic [VALUE_BITS-1:0] mem_waddr;
  logic [MemW-1:0]       mem_wdata;
  logic [VALUE_BITS-1:0] mem_raddr;

  // Item and sequencing registers.
  logic [VALUE_BITS-1:0] value_q;
  logic                  last_q;
  logic [KW-1:0]         k_q;
  logic [RedW-1:0]       red_q;
  logic [VALUE_BITS-1:0] clr_q;
  logic [EpW-1:0]        epoch_q;
  logic [TotW-1:0]       total_q;
  logic [AccW-1:0]       acc_q, acc_d;
  logic [AccW-1:0]       mod_q;
  logic                  use_q;
  logic                  out_valid_q;
  logic [TotW-1:0]       out_total_q;
  logic                  out_final_q;

  // Partner address for the current power of two.
  logic [PowW-1:0]       power;
  logic [PowW-1:0]       partner;
  logic                  is_own;
  logic                  use_d;
  logic [COUNT_BITS-1:0] cnt_eff;
  logic [COUNT_BITS-1:0] cnt_inc;

  assign power   = PowW'(1) << k_q;
  assign partner = power - {1'b0, value_q};
  assign is_own  = (k_q == KOwn);
  assign use_d   = cmd_i.scan && !is_own && (power >= {1'b0, value_q}) && !partner[VALUE_BITS];
  assign mem_raddr = is_own ? value_q : partner[VALUE_BITS-1:0];

  // An entry written under another set tag counts as empty.
  assign cnt_eff = (rd_q[MemW-1 -: EpW] == epoch_q) ? rd_q[COUNT_BITS-1:0] : '0;
  assign cnt_inc = (&cnt_eff) ? cnt_eff : cnt_eff + COUNT_BITS'(1);

  // Memory write: clearing sweep, or write-back of the item's own count.
  assign mem_we    = cmd_i.clear || (cmd_i.reduce && (red_q == '0));
  assign mem_waddr = cmd_i.clear ? clr_q : value_q;
  assign mem_wdata = cmd_i.clear ? '0 : {epoch_q, cnt_inc};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.scan) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  // Accumulate while reading, then one compare-and-subtract per reduction step.
  always_comb begin
    acc_d = acc_q;
    if (cmd_i.load) begin
      acc_d = AccW'(total_q);
    end else if (cmd_i.reduce) begin
      acc_d = (acc_q >= mod_q) ? acc_q - mod_q : acc_q;
    end else if (use_q) begin
      acc_d = acc_q + AccW'(cnt_eff);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.load) begin
      value_q <= value_i;
      last_q  <= last_item_i;
      mod_q   <= ModTop;
    end else if (cmd_i.reduce) begin
      mod_q <= mod_q >> 1;
    end
    if (cmd_i.finish) begin
      out_total_q <= acc_q[TotW-1:0];
      out_final_q <= last_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      red_q       <= '0;
      clr_q       <= '0;
      epoch_q     <= '0;
      total_q     <= '0;
      use_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      use_q <= use_d;
      if (cmd_i.load) begin
        k_q   <= '0;
        red_q <= '0;
      end else begin
        if (cmd_i.scan) begin
          k_q <= k_q + KW'(1);
        end
        if (cmd_i.reduce) begin
          red_q <= red_q + RedW'(1);
        end
      end
      if (cmd_i.clear) begin
        clr_q <= clr_q + VALUE_BITS'(1);
        if (&clr_q) begin
          epoch_q <= EpW'(1);
        end
      end
      if (cmd_i.finish) begin
        total_q     <= last_q ? '0 : acc_q[TotW-1:0];
        out_valid_q <= 1'b1;
        if (last_q) begin
          epoch_q <= epoch_q + EpW'(1);
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Status to the controller.
  assign sts_o.clr_done  = &clr_q;
  assign sts_o.scan_done = is_own;
  assign sts_o.red_done  = (red_q == RedLast);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.wrap_next = last_q && (&epoch_q);

  assign out_valid_o  = out_valid_q;
  assign pair_total_o = out_total_q;
  assign is_final_o   = out_final_q;

endmodule

@@ hw/rtl/power_of_two_pair_counter.sv @@
// Per item: the beat is loaded, VALUE_BITS + 1 partner reads and one own read go through
// the single histogram read port, then accumulator width - 29 reduction steps run (2 at the
// default widths) and the result is registered; only then is a new input beat taken.
// A result waiting in the output register does not hold back the next input beat.
// Reset is asynchronous, active low; a clearing pass over all 2^VALUE_BITS entries follows
// reset and every fifteenth closed set, during which no input beat is taken.
module power_of_two_pair_counter #(
  parameter int unsigned VALUE_BITS = 12,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [VALUE_BITS-1:0]          value_i,
  input  logic                           last_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [p2pc_pkg::TotalBits-1:0] pair_total_o,
  output logic                           is_final_o
);

  p2pc_pkg::cmd_t cmd;
  p2pc_pkg::sts_t sts;

  // Sequencing of one item.
  p2pc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Histogram, accumulator and result register.
  p2pc_dpath #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .value_i      (value_i),
    .last_item_i  (last_item_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .pair_total_o (pair_total_o),
    .is_final_o   (is_final_o)
  );

endmodule

@@ dv/power_of_two_pair_counter_tb.sv @@
// Self-checking testbench for the power-of-two pair counter.
`timescale 1ns / 100ps

module power_of_two_pair_counter_tb;

  localparam int unsigned ValueBits  = 12;
  localparam int unsigned CountBits  = 16;
  localparam int unsigned HistDepth  = 1 << ValueBits;
  localparam int unsigned RandBeats  = 1400;
  localparam int unsigned DrainWait  = 60;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [ValueBits-1:0] value;
    logic                 last_item;
  } set_beat_t;

  typedef struct packed {
    logic [p2pc_pkg::TotalBits-1:0] pair_total;
    logic                           is_final;
  } pair_result_t;

  // Clock, reset and the block's inputs, all known from time zero.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid    = 1'b0;
  logic [ValueBits-1:0] value_in    = '0;
  logic                 last_in     = 1'b0;
  logic                 out_stall   = 1'b0;
  logic                                in_stall;
  logic                                out_valid;
  logic [p2pc_pkg::TotalBits-1:0]      pair_total;
  logic                                is_final;

  // Pending beats, expected results and the shadow copy of the counter state.
  set_beat_t                  pending_beats[$];
  pair_result_t               expected_totals[$];
  logic [CountBits-1:0]       hist_model[HistDepth];
  logic [p2pc_pkg::TotalBits-1:0] total_model;
  int unsigned                beats_sent  = 0;
  int unsigned                total_beats = 1;
  int unsigned                fail_count  = 0;
  int unsigned                cycle_count = 0;

  power_of_two_pair_counter #(
    .VALUE_BITS (ValueBits),
    .COUNT_BITS (CountBits)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .value_i      (value_in),
    .last_item_i  (last_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .pair_total_o (pair_total),
    .is_final_o   (is_final)
  );

  always #5 clk_i = ~clk_i;

  // Empty the shadow histogram and total, as after reset or a closed set.
  task automatic clear_set_model();
    for (int i = 0; i < HistDepth; i++) begin
      hist_model[i] = '0;
    end
    total_model = '0;
  endtask

  // Add the pairs that one accepted value closes and queue the expected result.
  task automatic count_pairs(input logic [ValueBits-1:0] value, input logic last_item);
    logic [63:0]  acc;
    int unsigned  power;
    int unsigned  partner;
    pair_result_t res;
    acc = total_model;
    for (int k = 0; k <= ValueBits; k++) begin
      power = 1 << k;
      if (power >= value) begin
        partner = power - value;
        // A partner of 2^ValueBits has no histogram entry.
        if (partner < HistDepth) begin
          acc = (acc + hist_model[partner]) % p2pc_pkg::PairModulus;
        end
      end
    end
    total_model = acc[p2pc_pkg::TotalBits-1:0];
    // Counts stick at their maximum.
    if (hist_model[value] != '1) begin
      hist_model[value] = hist_model[value] + 1'b1;
    end
    res.pair_total = total_model;
    res.is_final   = last_item;
    expected_totals.push_back(res);
    if (last_item) begin
      clear_set_model();
    end
  endtask

  function automatic void add_beat(input int unsigned value, input bit last_item);
    set_beat_t b;
    b.value     = value[ValueBits-1:0];
    b.last_item = last_item;
    pending_beats.push_back(b);
  endfunction

  // Idle percentage of each side for the part of the run now under way.
  function automatic int unsigned idle_pct(input bit sender);
    int unsigned part;
    part = beats_sent * 3 / total_beats;
    if (part == 0) begin
      return sender ? 38 : 50;
    end else if (part == 1) begin
      return sender ? 50 : 38;
    end
    return 0;
  endfunction

  // Driver: present queued beats, holding each one while it is stalled.
  always @(posedge clk_i or negedge rst_ni) begin : drive_beats
    set_beat_t next_beat;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      value_in <= '0;
      last_in  <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        count_pairs(value_in, last_in);
        beats_sent <= beats_sent + 1;
      end
      if (pending_beats.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
        next_beat = pending_beats.pop_front();
        value_in  <= next_beat.value;
        last_in   <= next_beat.last_item;
        in_valid  <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted result beat with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    pair_result_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_totals.size() == 0) begin
          $error("unexpected result beat: pair_total %0d is_final %0b", pair_total, is_final);
          fail_count++;
        end else begin
          want = expected_totals.pop_front();
          if (pair_total !== want.pair_total) begin
            $error("pair_total: expected %0d, actual %0d", want.pair_total, pair_total);
            fail_count++;
          end
          if (is_final !== want.is_final) begin
            $error("is_final: expected %0b, actual %0b", want.is_final, is_final);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct(1'b0));
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : run_sequence
    int unsigned base_val[3];
    int unsigned mate_val[3];
    int unsigned set_len;
    int unsigned roll;
    int unsigned power;
    int unsigned lo;
    int unsigned pick;
    int unsigned v;
    int unsigned rand_goal;

    clear_set_model();

    // Single-item sets at both ends of the value range close with no pairs.
    add_beat(0, 1'b1);
    add_beat(HistDepth - 1, 1'b1);
    // Self pairs, zero whose top partner lies outside the histogram,
    // the top value pairing with one, and the middle value pairing with itself.
    add_beat(1, 1'b0);
    add_beat(1, 1'b0);
    add_beat(3, 1'b0);
    add_beat(0, 1'b0);
    add_beat(0, 1'b0);
    add_beat(HistDepth - 1, 1'b0);
    add_beat(HistDepth / 2, 1'b0);
    add_beat(HistDepth / 2, 1'b0);
    add_beat(HistDepth - 2, 1'b0);
    add_beat(2, 1'b0);
    add_beat(HistDepth - 1, 1'b1);
    // The set after a close starts from nothing.
    add_beat(1, 1'b0);
    add_beat(1, 1'b0);
    add_beat(HistDepth / 2 - 1, 1'b0);
    add_beat(HistDepth / 2 + 1, 1'b0);
    add_beat(HistDepth - 1, 1'b1);

    // Random sets built around complementary value pairs.
    rand_goal = pending_beats.size() + RandBeats;
    while (pending_beats.size() < rand_goal) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        set_len = $urandom_range(2, 1);
      end else if (roll < 90) begin
        set_len = $urandom_range(30, 2);
      end else begin
        set_len = $urandom_range(80, 31);
      end
      for (int j = 0; j < 3; j++) begin
        power = 1 << $urandom_range(ValueBits, 0);
        lo = (power > HistDepth - 1) ? power - (HistDepth - 1) : 0;
        base_val[j] = $urandom_range((power < HistDepth) ? power : HistDepth - 1, lo);
        mate_val[j] = power - base_val[j];
      end
      for (int i = 0; i < set_len; i++) begin
        roll = $urandom_range(99);
        if (roll < 70) begin
          pick = $urandom_range(2);
          v = $urandom_range(1) ? base_val[pick] : mate_val[pick];
        end else if (roll < 85) begin
          v = $urandom_range(15);
        end else begin
          v = $urandom_range(HistDepth - 1);
        end
        add_beat(v, i == set_len - 1);
      end
    end
    total_beats = pending_beats.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every beat to be taken and every result to come back.
    while (pending_beats.size() > 0 || in_valid || expected_totals.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DrainWait) @(posedge clk_i);

    if (expected_totals.size() != 0) begin
      $error("%0d expected results never arrived", expected_totals.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/p2pc_pkg.sv
hw/rtl/p2pc_ctrl.sv
hw/rtl/p2pc_dpath.sv
hw/rtl/power_of_two_pair_counter.sv
dv/power_of_two_pair_counter_tb.sv
